### rtl/wes_pkg.sv
// ---------------------------------------------------------------------------
// wes_pkg: shared types and constants for the wealth exchange step core
// Item layouts, register indexes, opcodes, exchange modes, sequencer states
// and the small saturation and clamp helpers.
// ---------------------------------------------------------------------------
package wes_pkg;

	localparam int unsigned AGENTS_DEF = 1024;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [16:0] Q16_ONE = 17'h10000;

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXCHANGE_MODE   = 3'd0,
		CFG_SAVING_FRACTION = 3'd1,
		CFG_COUPLING        = 3'd2,
		CFG_AVERAGE_WEALTH  = 3'd3,
		CFG_AGENT_COUNT     = 3'd4
	} cfg_idx_t;

	localparam logic [1:0]  MODE_RESET     = 2'd0;
	localparam logic [16:0] SAVING_RESET   = 17'd0;
	localparam logic [16:0] COUPLING_RESET = 17'd0;
	localparam logic [31:0] AVG_RESET      = 32'h0001_0000;
	localparam logic [10:0] COUNT_RESET    = 11'd1024;

	localparam logic [1:0] OP_EXCHANGE = 2'd0;
	localparam logic [1:0] OP_LOAD     = 2'd1;
	localparam logic [1:0] OP_READ     = 2'd2;

	localparam logic [1:0] MODE_RANDOM = 2'd0;
	localparam logic [1:0] MODE_SAVING = 2'd1;
	localparam logic [1:0] MODE_FIELD  = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [9:0]  agent_a;
		logic [9:0]  agent_b;
		logic [16:0] fraction;
		logic [31:0] load_value;
	} wes_in_t;

	typedef struct packed {
		logic [31:0] balance_a;
		logic [31:0] balance_b;
		logic        applied;
		logic        status;
	} wes_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WR_LD,
		S_RD_A,
		S_RD_B,
		S_CAP_B,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_MUL4,
		S_FIN,
		S_WR_A,
		S_WR_B,
		S_OUT
	} state_t;

	function automatic logic [16:0] clamp_one(input logic [16:0] v);
		return (v > Q16_ONE) ? Q16_ONE : v;
	endfunction

	function automatic logic [31:0] sat32(input logic [35:0] v);
		return (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

### rtl/wes_chan_if.sv
// ---------------------------------------------------------------------------
// wes_chan_if: valid/ready channel
// Carries one payload item per handshake from source to sink.
// ---------------------------------------------------------------------------
interface wes_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### rtl/wealth_exchange_step_core.sv
// exchange: reads both balances from the single-port wealth ram, makes four
// passes through the shared 17x33 multiplier and writes both back, but skips
// the writes when the model rejects it; no new item is taken before the result
// is delivered. load: writes agent_a, then reads agent_b unless out of range;
// read, same-agent or undefined-mode exchange: reads only; index out of range: no ram access.
// async reset idles the sequencer and restores register defaults; the store is left uncleared.
// ---------------------------------------------------------------------------
// wealth_exchange_step_core: kinetic wealth exchange over a store of agents
// Random transfer, saving propensity and mean-field exchange on Q16.16
// balances, plus load and read of single entries.
// ---------------------------------------------------------------------------
module wealth_exchange_step_core #(
	parameter int unsigned AGENTS = wes_pkg::AGENTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wes_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	wes_chan_if.sink                         cmd,
	wes_chan_if.source                       res
);

	localparam int unsigned AW = (AGENTS > 1) ? $clog2(AGENTS) : 1;
	localparam logic [16:0] AGENTS_L = 17'(AGENTS);

	// configuration registers
	logic [1:0]  mode_q;
	logic [16:0] saving_q;
	logic [16:0] coupling_q;
	logic [31:0] avg_q;
	logic [10:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= wes_pkg::MODE_RESET;
			saving_q   <= wes_pkg::SAVING_RESET;
			coupling_q <= wes_pkg::COUPLING_RESET;
			avg_q      <= wes_pkg::AVG_RESET;
			count_q    <= wes_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			case (wes_pkg::cfg_idx_t'(cfg_index))
				wes_pkg::CFG_EXCHANGE_MODE:   mode_q     <= cfg_wdata[1:0];
				wes_pkg::CFG_SAVING_FRACTION: saving_q   <= cfg_wdata[16:0];
				wes_pkg::CFG_COUPLING:        coupling_q <= cfg_wdata[16:0];
				wes_pkg::CFG_AVERAGE_WEALTH:  avg_q      <= cfg_wdata;
				wes_pkg::CFG_AGENT_COUNT:     count_q    <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	// index limit is min(agent_count, AGENTS)
	logic [16:0] lim;
	logic        oka, okb;
	assign lim = (17'(count_q) > AGENTS_L) ? AGENTS_L : 17'(count_q);
	assign oka = 17'(cmd.payload.agent_a) < lim;
	assign okb = 17'(cmd.payload.agent_b) < lim;

	wes_pkg::state_t state_q, state_d;

	logic [1:0]  op_q;
	logic [9:0]  ia_q, ib_q;
	logic [16:0] nu_q;
	logic        okb_q;
	logic [31:0] a_q, b_q;
	logic        applied_q, status_q;
	logic        neg_q;
	logic [33:0] h1_q, h2_q, h3_q;
	logic [49:0] prod_q;

	logic [16:0] lam, jc;
	logic [32:0] sum_ab;
	logic        neg;
	logic [31:0] diff_mag;
	logic [16:0] mul_x;
	logic [32:0] mul_y;

	logic        ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0] ram_wdata, ram_rdata;

	logic        accept;
	logic        skip_mul;
	logic        fin_ok;
	logic [31:0] fin_a, fin_b;

	assign accept = cmd.valid && cmd.ready;
	assign lam    = wes_pkg::clamp_one(saving_q);
	assign jc     = wes_pkg::clamp_one(coupling_q);
	assign sum_ab = {1'b0, a_q} + {1'b0, b_q};
	assign neg    = avg_q < a_q;
	assign diff_mag = neg ? (a_q - avg_q) : (avg_q - a_q);
	assign skip_mul = (op_q != wes_pkg::OP_EXCHANGE) || (ia_q == ib_q) ||
		!(mode_q inside {wes_pkg::MODE_RANDOM, wes_pkg::MODE_SAVING, wes_pkg::MODE_FIELD});

	// shared multiplier operand select
	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (state_q)
			wes_pkg::S_MUL1: begin
				case (mode_q)
					wes_pkg::MODE_RANDOM: begin
						mul_x = nu_q;
						mul_y = sum_ab;
					end
					wes_pkg::MODE_SAVING: begin
						mul_x = wes_pkg::Q16_ONE - lam;
						mul_y = sum_ab;
					end
					wes_pkg::MODE_FIELD: begin
						mul_x = jc;
						mul_y = {1'b0, diff_mag};
					end
					default: ;
				endcase
			end
			wes_pkg::S_MUL2: begin
				mul_x = (mode_q == wes_pkg::MODE_SAVING) ? lam : nu_q;
				mul_y = {1'b0, a_q};
			end
			wes_pkg::S_MUL3: begin
				mul_x = nu_q;
				mul_y = h1_q[32:0];
			end
			wes_pkg::S_MUL4: begin
				mul_x = lam;
				mul_y = {1'b0, b_q};
			end
			default: ;
		endcase
	end

	// final balances per model
	logic [32:0]        dm0;
	logic signed [35:0] t_s, dm2, na2, nb2;
	logic signed [35:0] a_s, b_s;

	assign dm0 = h1_q[33:1];
	assign a_s = $signed({4'b0, a_q});
	assign b_s = $signed({4'b0, b_q});
	assign t_s = neg_q ? -$signed({4'b0, h1_q[31:0]}) : $signed({4'b0, h1_q[31:0]});
	assign dm2 = t_s + $signed({4'b0, h2_q[31:0]});
	assign na2 = a_s - dm2;
	assign nb2 = b_s + dm2;

	always_comb begin
		fin_ok = 1'b0;
		fin_a  = a_q;
		fin_b  = b_q;
		case (mode_q)
			wes_pkg::MODE_RANDOM: begin
				fin_ok = {1'b0, a_q} > dm0;
				fin_a  = a_q - dm0[31:0];
				fin_b  = wes_pkg::sat32(36'(b_q) + 36'(dm0));
			end
			wes_pkg::MODE_SAVING: begin
				fin_ok = 1'b1;
				fin_a  = wes_pkg::sat32(36'(h2_q[31:0]) + 36'(h3_q[32:0]));
				fin_b  = wes_pkg::sat32(36'(prod_q[47:16]) + 36'(h1_q[32:0])
					- 36'(h3_q[32:0]));
			end
			wes_pkg::MODE_FIELD: begin
				fin_ok = (na2 > 36'sd0) && (nb2 > 36'sd0);
				fin_a  = wes_pkg::sat32(36'(na2));
				fin_b  = wes_pkg::sat32(36'(nb2));
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wes_pkg::S_IDLE: begin
				if (accept) begin
					if (cmd.payload.opcode == wes_pkg::OP_LOAD) begin
						state_d = oka ? wes_pkg::S_WR_LD : wes_pkg::S_OUT;
					end else begin
						state_d = (oka && okb) ? wes_pkg::S_RD_A : wes_pkg::S_OUT;
					end
				end
			end
			wes_pkg::S_WR_LD: state_d = okb_q ? wes_pkg::S_RD_B : wes_pkg::S_OUT;
			wes_pkg::S_RD_A:  state_d = wes_pkg::S_RD_B;
			wes_pkg::S_RD_B:  state_d = wes_pkg::S_CAP_B;
			wes_pkg::S_CAP_B: state_d = skip_mul ? wes_pkg::S_OUT : wes_pkg::S_MUL1;
			wes_pkg::S_MUL1:  state_d = wes_pkg::S_MUL2;
			wes_pkg::S_MUL2:  state_d = wes_pkg::S_MUL3;
			wes_pkg::S_MUL3:  state_d = wes_pkg::S_MUL4;
			wes_pkg::S_MUL4:  state_d = wes_pkg::S_FIN;
			wes_pkg::S_FIN:   state_d = fin_ok ? wes_pkg::S_WR_A : wes_pkg::S_OUT;
			wes_pkg::S_WR_A:  state_d = wes_pkg::S_WR_B;
			wes_pkg::S_WR_B:  state_d = wes_pkg::S_OUT;
			wes_pkg::S_OUT:   state_d = res.ready ? wes_pkg::S_IDLE : wes_pkg::S_OUT;
			default:          state_d = wes_pkg::S_IDLE;
		endcase
	end

	// outputs and ram control
	always_comb begin
		cmd.ready = 1'b0;
		res.valid = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = AW'(ib_q);
		ram_wdata = b_q;
		case (state_q)
			wes_pkg::S_IDLE: cmd.ready = 1'b1;
			wes_pkg::S_WR_LD: begin
				ram_we    = 1'b1;
				ram_addr  = AW'(ia_q);
				ram_wdata = a_q;
			end
			wes_pkg::S_RD_A: ram_addr = AW'(ia_q);
			wes_pkg::S_WR_A: begin
				ram_we    = 1'b1;
				ram_addr  = AW'(ia_q);
				ram_wdata = a_q;
			end
			wes_pkg::S_WR_B: ram_we = 1'b1;
			wes_pkg::S_OUT:  res.valid = 1'b1;
			default: ;
		endcase
	end

	assign res.payload.balance_a = a_q;
	assign res.payload.balance_b = b_q;
	assign res.payload.applied   = applied_q;
	assign res.payload.status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wes_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= 50'(mul_x) * 50'(mul_y);
		case (state_q)
			wes_pkg::S_IDLE: begin
				if (accept) begin
					op_q      <= cmd.payload.opcode;
					ia_q      <= cmd.payload.agent_a;
					ib_q      <= cmd.payload.agent_b;
					nu_q      <= wes_pkg::clamp_one(cmd.payload.fraction);
					okb_q     <= okb;
					// a flagged load reports zero balances
					a_q       <= (cmd.payload.opcode == wes_pkg::OP_LOAD && oka) ?
						cmd.payload.load_value : 32'd0;
					b_q       <= 32'd0;
					applied_q <= 1'b0;
					status_q  <= (cmd.payload.opcode == wes_pkg::OP_LOAD) ? !oka :
						!(oka && okb);
				end
			end
			wes_pkg::S_WR_LD: applied_q <= 1'b1;
			wes_pkg::S_RD_B: begin
				if (op_q != wes_pkg::OP_LOAD) begin
					a_q <= ram_rdata;
				end
			end
			wes_pkg::S_CAP_B: b_q <= ram_rdata;
			wes_pkg::S_MUL1: neg_q <= neg;
			wes_pkg::S_MUL2: h1_q <= prod_q[49:16];
			wes_pkg::S_MUL3: h2_q <= prod_q[49:16];
			wes_pkg::S_MUL4: h3_q <= prod_q[49:16];
			wes_pkg::S_FIN: begin
				if (fin_ok) begin
					a_q       <= fin_a;
					b_q       <= fin_b;
					applied_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	wes_ram #(
		.WIDTH(32),
		.DEPTH(AGENTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ready && res.valid))
		else $error("input taken while a result is pending");

	a_flag_not_applied: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.payload.status) |-> !res.payload.applied)
		else $error("out-of-range item reported as applied");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready) |=> cmd.ready)
		else $error("not ready after result delivered");

	a_pair_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wes_pkg::S_WR_B) |-> ($past(state_q) == wes_pkg::S_WR_A))
		else $error("second write-back without the first");

endmodule

### rtl/wes_ram.sv
// ---------------------------------------------------------------------------
// wes_ram: generic single-port ram
// One access per cycle, a read or a write (which also returns the old data), with registered read data.
// ---------------------------------------------------------------------------
module wes_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
